// ----- sv/tapa_pkg.sv -----
// ---------------------------------------------------------------------------
// tapa_pkg
// Shared types and constants for the tunnel address pool allocator.
// ---------------------------------------------------------------------------
package tapa_pkg;

  localparam int unsigned OFFSET_W = 8;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PREFIX_W = ADDR_W - OFFSET_W;
  localparam int unsigned MARK_DEPTH = 1 << OFFSET_W;

  // host offsets that may be handed out
  localparam logic [OFFSET_W-1:0] HOST_MIN  = 8'd2;
  localparam logic [OFFSET_W-1:0] HOST_MAX  = 8'd254;
  localparam logic [OFFSET_W:0]   HOST_WRAP = 9'd255;

  localparam logic ACT_RESERVE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DESIRED,
    ST_SEARCH,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] desired;
    logic [ADDR_W-1:0] released;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              full;
  } res_t;

  // one read port and one write port of the used-mark memory
  typedef struct packed {
    logic                rd_en;
    logic [OFFSET_W-1:0] rd_addr;
    logic                wr_en;
    logic [OFFSET_W-1:0] wr_addr;
    logic                wr_data;
  } mark_req_t;

endpackage

// ----- sv/tapa_mark_ram.sv -----
// ---------------------------------------------------------------------------
// tapa_mark_ram
// Used-mark memory, one bit per host offset, registered read.
// ---------------------------------------------------------------------------
module tapa_mark_ram (
  input  logic                clk,
  input  tapa_pkg::mark_req_t req,
  output logic                rd_data
);
  import tapa_pkg::*;

  logic mem [MARK_DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/tapa_seq.sv -----
// ---------------------------------------------------------------------------
// tapa_seq
// Sequencer: clearing pass, desired-address check and next-fit search over
// the used-mark memory, one read per cycle.
// ---------------------------------------------------------------------------
module tapa_seq #(
  parameter int unsigned FIRST_AUTO_OFFSET = 100
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tapa_pkg::req_t                      req,
  input  logic [tapa_pkg::PREFIX_W-1:0]       prefix,
  output logic                                res_valid,
  input  logic                                res_ready,
  output tapa_pkg::res_t                      res,
  output tapa_pkg::mark_req_t                 mark_req,
  input  logic                                mark_rdata
);
  import tapa_pkg::*;

  localparam logic [OFFSET_W-1:0] FIRST_OFF = OFFSET_W'(FIRST_AUTO_OFFSET);
  localparam logic [OFFSET_W-1:0] LAST_INIT = OFFSET_W'(FIRST_AUTO_OFFSET - 1);
  // index of the final visit of a search
  localparam logic [OFFSET_W-1:0] SRCH_LAST = OFFSET_W'(254 - FIRST_AUTO_OFFSET);

  function automatic logic [OFFSET_W-1:0] next_off(input logic [OFFSET_W-1:0] x);
    logic [OFFSET_W:0] s;
    s = {1'b0, x} + 9'd1;
    return (s >= HOST_WRAP) ? FIRST_OFF : s[OFFSET_W-1:0];
  endfunction

  state_t              state_r, state_nxt;
  logic [OFFSET_W-1:0] clr_cnt_r;
  logic [OFFSET_W-1:0] last_r;
  logic [OFFSET_W-1:0] srch_off_r;
  logic [OFFSET_W-1:0] srch_cnt_r;
  logic [ADDR_W-1:0]   req_addr_r;
  logic [ADDR_W-1:0]   res_addr_r;
  logic                res_full_r;

  logic [OFFSET_W-1:0] des_off;
  logic                des_ok;
  logic                srch_done;
  logic                rel_hit;

  assign des_off   = req_addr_r[OFFSET_W-1:0];
  assign des_ok    = (req_addr_r[ADDR_W-1:OFFSET_W] == prefix) && (des_off >= HOST_MIN)
                     && (des_off <= HOST_MAX) && !mark_rdata;
  assign srch_done = (srch_cnt_r == SRCH_LAST);
  assign rel_hit   = (req.released[ADDR_W-1:OFFSET_W] == prefix);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == {OFFSET_W{1'b1}}) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (req.action == ACT_RELEASE) ? ST_RESULT : ST_DESIRED;
        end
      end
      ST_DESIRED: begin
        state_nxt = des_ok ? ST_RESULT : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!mark_rdata || srch_done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // memory accesses; the single-item flow keeps a write and a read of the
  // same entry from ever overlapping
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mark_req  = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mark_req.wr_en   = 1'b1;
        mark_req.wr_addr = clr_cnt_r;
        mark_req.wr_data = 1'b0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req.action == ACT_RELEASE) begin
            mark_req.wr_en   = rel_hit;
            mark_req.wr_addr = req.released[OFFSET_W-1:0];
            mark_req.wr_data = 1'b0;
          end else begin
            mark_req.rd_en   = 1'b1;
            mark_req.rd_addr = req.desired[OFFSET_W-1:0];
          end
        end
      end
      ST_DESIRED: begin
        if (des_ok) begin
          mark_req.wr_en   = 1'b1;
          mark_req.wr_addr = des_off;
          mark_req.wr_data = 1'b1;
        end else begin
          mark_req.rd_en   = 1'b1;
          mark_req.rd_addr = next_off(last_r);
        end
      end
      ST_SEARCH: begin
        if (!mark_rdata) begin
          mark_req.wr_en   = 1'b1;
          mark_req.wr_addr = srch_off_r;
          mark_req.wr_data = 1'b1;
        end else if (!srch_done) begin
          mark_req.rd_en   = 1'b1;
          mark_req.rd_addr = next_off(srch_off_r);
        end
      end
      ST_RESULT: begin
        res_valid = 1'b1;
      end
      default: begin
        mark_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      last_r    <= LAST_INIT;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 8'd1;
      // every visited offset moves the resume point, also on a full pool
      if (state_r == ST_SEARCH) last_r <= srch_off_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        req_addr_r <= req.desired;
        res_addr_r <= '0;
        res_full_r <= 1'b0;
      end
      ST_DESIRED: begin
        if (des_ok) begin
          res_addr_r <= req_addr_r;
        end else begin
          srch_off_r <= next_off(last_r);
          srch_cnt_r <= '0;
        end
      end
      ST_SEARCH: begin
        if (!mark_rdata) begin
          res_addr_r <= {prefix, srch_off_r};
        end else if (srch_done) begin
          res_full_r <= 1'b1;
        end else begin
          srch_off_r <= next_off(srch_off_r);
          srch_cnt_r <= srch_cnt_r + 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.addr = res_addr_r;
  assign res.full = res_full_r;

endmodule

// ----- sv/tunnel_address_pool_allocator.sv -----
// ---------------------------------------------------------------------------
// tunnel_address_pool_allocator
// Reserves and releases host addresses of one /24 network, next-fit search
// over a used-mark memory.
// ---------------------------------------------------------------------------
// release: the result state follows the transaction, then the output register
// reserve, desired address free: the desired-address check state, then the result state
// reserve, search: k visited offsets, at most 255 - FIRST_AUTO_OFFSET, before the result state
//   (one memory read per visited offset); a new transaction is taken only back in idle
// reset: a clearing pass over all 256 mark entries, in_tready low meanwhile;
//   network prefix resets to 0
module tunnel_address_pool_allocator #(
  parameter int unsigned FIRST_AUTO_OFFSET = 100
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // desired_address, released_address
  input  logic                           in_tuser,   // action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tapa_pkg::ADDR_W-1:0]    out_tdata,  // assigned_address
  output logic                           out_tuser,  // pool_full
  input  logic                           cfg_wr_en,
  input  logic [tapa_pkg::PREFIX_W-1:0]  cfg_wr_data // network_prefix
);
  import tapa_pkg::*;

  logic [PREFIX_W-1:0] prefix_r;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic                out_full_r;

  req_t      req;
  res_t      res;
  mark_req_t mark_req;
  logic      mark_rdata;
  logic      res_valid;
  logic      res_ready;

  assign req.action   = in_tuser;
  assign req.desired  = in_tdata[ADDR_W-1:0];
  assign req.released = in_tdata[2*ADDR_W-1:ADDR_W];

  assign res_ready = !out_valid_r || out_tready;

  tapa_seq #(
    .FIRST_AUTO_OFFSET(FIRST_AUTO_OFFSET)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .req       (req),
    .prefix    (prefix_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mark_req  (mark_req),
    .mark_rdata(mark_rdata)
  );

  tapa_mark_ram u_mark_ram (
    .clk    (clk),
    .req    (mark_req),
    .rd_data(mark_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) prefix_r <= cfg_wr_data;
      if (res_ready) out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_addr_r <= res.addr;
      out_full_r <= res.full;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_full_r;

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("pool full result carries a nonzero address");

  a_grant_in_net: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata != '0) |->
      (out_tdata[ADDR_W-1:OFFSET_W] == prefix_r) &&
      (out_tdata[OFFSET_W-1:0] >= HOST_MIN) && (out_tdata[OFFSET_W-1:0] <= HOST_MAX))
    else $error("granted address outside the pool");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("transaction taken before the clearing pass");

endmodule
